// File: sv/csbc_pkg.sv
package csbc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int COORD_WIDTH = 32;
  localparam int PROD_WIDTH = 64;

  localparam logic [1:0] KIND_LOAD_VP = 2'd0;
  localparam logic [1:0] KIND_LOAD_MODEL = 2'd1;
  localparam logic [1:0] KIND_TEST_BOX = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] row_index;
    logic signed [31:0] elem0;
    logic signed [31:0] elem1;
    logic signed [31:0] elem2;
    logic signed [31:0] elem3;
    logic signed [31:0] min_x;
    logic signed [31:0] min_y;
    logic signed [31:0] min_z;
    logic signed [31:0] max_x;
    logic signed [31:0] max_y;
    logic signed [31:0] max_z;
  } in_item_t;

  typedef struct packed {
    logic visible;
    logic [2:0] separating_axes;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load_box;   // capture box extents, set all axis flags
    logic clip_step;  // compute one clip element (index = idx[3:0])
    logic corner_step; // one clip row of one corner (corner = idx[4:2], phase = idx[1:0])
    logic [4:0] idx;
  } dp_cmd_t;

  // arithmetic shift right by FRAC_BITS, then saturate
  function automatic logic signed [COORD_WIDTH-1:0] shift_sat(
      input logic signed [PROD_WIDTH-1:0] acc);
    logic signed [PROD_WIDTH-1:0] s;
    logic signed [PROD_WIDTH-1:0] hi;
    logic signed [PROD_WIDTH-1:0] lo;
    begin
      s = acc >>> FRAC_BITS;
      hi = (PROD_WIDTH'(1) <<< (COORD_WIDTH - 1)) - PROD_WIDTH'(1);
      lo = -hi - PROD_WIDTH'(1);
      if (s > hi) s = hi;
      else if (s < lo) s = lo;
      shift_sat = s[COORD_WIDTH-1:0];
    end
  endfunction

endpackage

// File: sv/csbc_datapath.sv
module csbc_datapath (
  input  logic clk,
  input  csbc_pkg::in_item_t in_data,
  input  logic load_row,
  input  csbc_pkg::dp_cmd_t cmd,
  input  logic rst_n,
  output logic [2:0] sep
);

  localparam int CW = csbc_pkg::COORD_WIDTH;
  localparam int PW = csbc_pkg::PROD_WIDTH;

  logic signed [31:0] vp_r [16];
  logic signed [31:0] md_r [16];
  logic signed [CW-1:0] clip_r [16];
  logic signed [31:0] lo_r [3];
  logic signed [31:0] hi_r [3];
  logic [2:0] pos_r, neg_r;
  logic signed [CW-1:0] w_r;

  logic signed [PW-1:0] pa [4];
  logic signed [PW-1:0] acc;
  logic signed [31:0] pt [4];
  logic signed [31:0] opa [4];
  logic signed [31:0] opb [4];
  logic signed [CW-1:0] res;
  logic [1:0] ri, ci, phase, crow;
  logic [2:0] corner;

  assign ri = cmd.idx[3:2];
  assign ci = cmd.idx[1:0];
  assign corner = cmd.idx[4:2];
  assign phase = cmd.idx[1:0];
  // w row first, then x, y, z rows
  assign crow = (phase == 2'd0) ? 2'd3 : phase - 2'd1;

  // four shared products per cycle: one clip element or one clip row of a corner
  always_comb begin
    pt[0] = corner[0] ? hi_r[0] : lo_r[0];
    pt[1] = corner[1] ? hi_r[1] : lo_r[1];
    pt[2] = corner[2] ? hi_r[2] : lo_r[2];
    pt[3] = 32'sd1 <<< csbc_pkg::FRAC_BITS;
    for (int k = 0; k < 4; k++) begin
      if (cmd.corner_step) begin
        opa[k] = clip_r[{crow, 2'(k)}];
        opb[k] = pt[k];
      end else begin
        opa[k] = vp_r[{ri, 2'(k)}];
        opb[k] = md_r[{2'(k), ci}];
      end
      pa[k] = PW'(opa[k]) * PW'(opb[k]);
    end
    acc = pa[0] + pa[1] + pa[2] + pa[3];
    res = csbc_pkg::shift_sat(acc);
  end

  always_ff @(posedge clk) begin
    if (load_row) begin
      for (int j = 0; j < 4; j++) begin
        if (in_data.kind == csbc_pkg::KIND_LOAD_VP)
          vp_r[{in_data.row_index, 2'(j)}] <= (j == 0) ? in_data.elem0 :
            (j == 1) ? in_data.elem1 : (j == 2) ? in_data.elem2 : in_data.elem3;
        else
          md_r[{in_data.row_index, 2'(j)}] <= (j == 0) ? in_data.elem0 :
            (j == 1) ? in_data.elem1 : (j == 2) ? in_data.elem2 : in_data.elem3;
      end
    end
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) begin
        vp_r[i] <= '0;
        md_r[i] <= '0;
      end
    end
    if (cmd.clip_step) clip_r[cmd.idx[3:0]] <= res;
    if (cmd.load_box) begin
      lo_r[0] <= in_data.min_x; lo_r[1] <= in_data.min_y; lo_r[2] <= in_data.min_z;
      hi_r[0] <= in_data.max_x; hi_r[1] <= in_data.max_y; hi_r[2] <= in_data.max_z;
      pos_r <= 3'b111;
      neg_r <= 3'b111;
    end else if (cmd.corner_step) begin
      if (phase == 2'd0) begin
        w_r <= res;
      end else begin
        if (!(res >= w_r)) pos_r[crow] <= 1'b0;
        if (!(PW'(res) <= -PW'(w_r))) neg_r[crow] <= 1'b0;
      end
    end
  end

  assign sep = pos_r | neg_r;

endmodule

// File: sv/csbc_ctrl.sv
module csbc_ctrl (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic [1:0] in_kind,
  output logic in_ready,
  output logic load_row,
  output csbc_pkg::dp_cmd_t cmd,
  output logic out_valid,
  input  logic out_ready
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_CLIP = 4'b0010, S_CORN = 4'b0100, S_DONE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic [4:0] idx_r, idx_nxt;
  logic out_valid_r, out_valid_nxt;
  logic acc_in;

  assign in_ready = (state_r == S_IDLE) && !out_valid_r;
  assign acc_in = in_valid && in_ready;
  assign load_row = acc_in && (in_kind == csbc_pkg::KIND_LOAD_VP ||
                               in_kind == csbc_pkg::KIND_LOAD_MODEL);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    idx_nxt = idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd = '0;
    cmd.idx = idx_r;
    case (state_r)
      S_IDLE: begin
        if (acc_in && in_kind == csbc_pkg::KIND_TEST_BOX) begin
          cmd.load_box = 1'b1;
          idx_nxt = '0;
          state_nxt = S_CLIP;
        end
      end
      S_CLIP: begin
        cmd.clip_step = 1'b1;
        idx_nxt = idx_r + 5'd1;
        if (idx_r == 5'd15) begin
          idx_nxt = '0;
          state_nxt = S_CORN;
        end
      end
      S_CORN: begin
        cmd.corner_step = 1'b1;
        idx_nxt = idx_r + 5'd1;
        if (idx_r == 5'd31) state_nxt = S_DONE;
      end
      S_DONE: begin
        out_valid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: sv/clip_space_box_cull_unit.sv
// Box culling against the clip volume. Kind 0/1 beats each load one row of the
// view-projection or model matrix, back to back while no result is waiting. A kind 2 beat
// forms the clip matrix one element per cycle, then works through the 8 box
// corners one clip row per cycle, w row first, all on four shared multipliers;
// the result is registered as the controller leaves its DONE state, and the next
// beat is taken the cycle after the result has been taken.
module clip_space_box_cull_unit (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  csbc_pkg::in_item_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output csbc_pkg::out_item_t out_data
);

  csbc_pkg::dp_cmd_t cmd;
  logic load_row;
  logic [2:0] sep;

  csbc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_kind(in_data.kind),
    .in_ready(in_ready), .load_row(load_row), .cmd(cmd),
    .out_valid(out_valid), .out_ready(out_ready)
  );

  csbc_datapath u_dp (
    .clk(clk), .in_data(in_data), .load_row(load_row), .cmd(cmd),
    .rst_n(rst_n), .sep(sep)
  );

  assign out_data.separating_axes = sep;
  assign out_data.visible = (sep == 3'b000);

endmodule

// File: bench/clip_space_box_cull_unit_tb.sv
module clip_space_box_cull_unit_tb;

  localparam logic [1:0] KIND_IGNORED = 2'd3;
  localparam int ONE_Q = 1 << csbc_pkg::FRAC_BITS;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  csbc_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  csbc_pkg::out_item_t out_data;

  clip_space_box_cull_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  csbc_pkg::in_item_t pending_items[$];
  csbc_pkg::out_item_t expected_verdicts[$];
  logic signed [63:0] vp_rows[16];
  logic signed [63:0] model_rows[16];
  int errors = 0;
  int cycle_count = 0;
  bit calm_phase = 1'b0;
  bit stimulus_done = 1'b0;
  bit hold_req = 1'b0;
  bit hold_started = 1'b0;
  int hold_off_cycles = 0;
  int send_gap = 0;
  int recv_gap = 0;

  // wrapping 64-bit accumulate, arithmetic shift, saturate to coord width
  function automatic logic signed [63:0] fixed_dot4(
      input logic signed [63:0] a0, a1, a2, a3, b0, b1, b2, b3);
    logic signed [63:0] acc;
    logic signed [63:0] hi;
    begin
      acc = a0 * b0 + a1 * b1 + a2 * b2 + a3 * b3;
      acc = acc >>> csbc_pkg::FRAC_BITS;
      hi = (64'sd1 <<< (csbc_pkg::COORD_WIDTH - 1)) - 64'sd1;
      if (acc > hi) acc = hi;
      else if (acc < -hi - 64'sd1) acc = -hi - 64'sd1;
      return acc;
    end
  endfunction

  task automatic predict_item(input csbc_pkg::in_item_t it);
    logic signed [63:0] clip[16];
    logic signed [63:0] lo[3];
    logic signed [63:0] hi[3];
    logic signed [63:0] pt[4];
    logic signed [63:0] co[4];
    bit pos[3];
    bit neg[3];
    logic [2:0] sep;
    csbc_pkg::out_item_t v;
    begin
      if (it.kind == csbc_pkg::KIND_LOAD_VP || it.kind == csbc_pkg::KIND_LOAD_MODEL) begin
        if (it.kind == csbc_pkg::KIND_LOAD_VP) begin
          vp_rows[it.row_index*4+0] = it.elem0;
          vp_rows[it.row_index*4+1] = it.elem1;
          vp_rows[it.row_index*4+2] = it.elem2;
          vp_rows[it.row_index*4+3] = it.elem3;
        end else begin
          model_rows[it.row_index*4+0] = it.elem0;
          model_rows[it.row_index*4+1] = it.elem1;
          model_rows[it.row_index*4+2] = it.elem2;
          model_rows[it.row_index*4+3] = it.elem3;
        end
      end else if (it.kind == csbc_pkg::KIND_TEST_BOX) begin
        for (int i = 0; i < 4; i++)
          for (int j = 0; j < 4; j++)
            clip[i*4+j] = fixed_dot4(vp_rows[i*4], vp_rows[i*4+1], vp_rows[i*4+2],
                                     vp_rows[i*4+3], model_rows[j], model_rows[4+j],
                                     model_rows[8+j], model_rows[12+j]);
        lo[0] = it.min_x; lo[1] = it.min_y; lo[2] = it.min_z;
        hi[0] = it.max_x; hi[1] = it.max_y; hi[2] = it.max_z;
        for (int i = 0; i < 3; i++) begin
          pos[i] = 1'b1;
          neg[i] = 1'b1;
        end
        for (int c = 0; c < 8; c++) begin
          pt[0] = c[0] ? hi[0] : lo[0];
          pt[1] = c[1] ? hi[1] : lo[1];
          pt[2] = c[2] ? hi[2] : lo[2];
          pt[3] = ONE_Q;
          for (int i = 0; i < 4; i++)
            co[i] = fixed_dot4(clip[i*4], clip[i*4+1], clip[i*4+2], clip[i*4+3],
                               pt[0], pt[1], pt[2], pt[3]);
          for (int i = 0; i < 3; i++) begin
            if (!(co[i] >= co[3])) pos[i] = 1'b0;
            if (!(co[i] <= -co[3])) neg[i] = 1'b0;
          end
        end
        for (int i = 0; i < 3; i++) sep[i] = pos[i] | neg[i];
        v.visible = (sep == 3'd0);
        v.separating_axes = sep;
        expected_verdicts.push_back(v);
      end
    end
  endtask

  function automatic logic [31:0] rand_q();
    logic [31:0] r;
    begin
      case ($urandom_range(0, 5))
        0: r = $urandom;
        1: r = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
        2: r = $urandom_range(0, 1) ? ONE_Q : -ONE_Q;
        3: r = 32'($signed($urandom_range(0, 8 * ONE_Q)) - 4 * ONE_Q);
        default: r = 32'($signed($urandom_range(0, 4 * ONE_Q)) - 2 * ONE_Q);
      endcase
      return r;
    end
  endfunction

  function automatic csbc_pkg::in_item_t make_row(input logic [1:0] k, input logic [1:0] r,
      input logic [31:0] e0, e1, e2, e3);
    csbc_pkg::in_item_t it;
    begin
      it = '0;
      it.kind = k; it.row_index = r;
      it.elem0 = e0; it.elem1 = e1; it.elem2 = e2; it.elem3 = e3;
      it.min_x = $urandom; it.max_z = $urandom;
      return it;
    end
  endfunction

  function automatic csbc_pkg::in_item_t make_box(input logic [31:0] x0, y0, z0, x1, y1, z1);
    csbc_pkg::in_item_t it;
    begin
      it.kind = csbc_pkg::KIND_TEST_BOX;
      it.row_index = 2'($urandom);
      it.elem0 = $urandom; it.elem1 = $urandom; it.elem2 = $urandom; it.elem3 = $urandom;
      it.min_x = x0; it.min_y = y0; it.min_z = z0;
      it.max_x = x1; it.max_y = y1; it.max_z = z1;
      return it;
    end
  endfunction

  task automatic load_identity(input logic [1:0] k);
    for (int r = 0; r < 4; r++)
      pending_items.push_back(make_row(k, r[1:0], r == 0 ? ONE_Q : 0, r == 1 ? ONE_Q : 0,
                                       r == 2 ? ONE_Q : 0, r == 3 ? ONE_Q : 0));
  endtask

  initial begin
    csbc_pkg::in_item_t it;
    int queued;
    int before_sz;
    bit held;
    for (int i = 0; i < 16; i++) begin
      vp_rows[i] = 0;
      model_rows[i] = 0;
    end
    // zero matrices: w = 0 and every coord 0, so all axes separate
    pending_items.push_back(make_box(0, 0, 0, ONE_Q, ONE_Q, ONE_Q));
    load_identity(csbc_pkg::KIND_LOAD_VP);
    load_identity(csbc_pkg::KIND_LOAD_MODEL);
    pending_items.push_back(make_box(-ONE_Q / 2, -ONE_Q / 2, -ONE_Q / 2,
                                     ONE_Q / 2, ONE_Q / 2, ONE_Q / 2));
    pending_items.push_back(make_box(2 * ONE_Q, 0, 0, 3 * ONE_Q, ONE_Q / 4, ONE_Q / 4));
    pending_items.push_back(make_box(0, -3 * ONE_Q, 0, ONE_Q / 4, -2 * ONE_Q, ONE_Q / 4));
    // min above max, extents used as given
    pending_items.push_back(make_box(ONE_Q, ONE_Q, ONE_Q, -ONE_Q, -ONE_Q, -ONE_Q));
    pending_items.push_back(make_box(32'h80000000, 32'h80000000, 32'h80000000,
                                     32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
    it = make_box(0, 0, 0, 0, 0, 0);
    it.kind = KIND_IGNORED;
    pending_items.push_back(it);
    // extreme elements: sum wrap and saturation
    pending_items.push_back(make_row(csbc_pkg::KIND_LOAD_VP, 2'd3, 32'h80000000,
                                     32'h80000000, 32'h7fffffff, 32'h80000000));
    pending_items.push_back(make_row(csbc_pkg::KIND_LOAD_MODEL, 2'd2, 32'h7fffffff,
                                     32'h80000000, 32'hffffffff, 32'h7fffffff));
    pending_items.push_back(make_box(32'h7fffffff, 32'h80000000, 32'hffffffff,
                                     32'h80000000, 32'h7fffffff, 0));
    pending_items.push_back(make_box(ONE_Q, ONE_Q, ONE_Q, 2 * ONE_Q, 2 * ONE_Q, 2 * ONE_Q));

    queued = pending_items.size();
    held = 1'b0;
    while (queued < 800) begin
      if (!held && queued >= 400) begin
        // drain the front half so the long hold-off backs up the block
        wait (pending_items.size() == 0);
        hold_req = 1'b1;
        held = 1'b1;
      end
      before_sz = pending_items.size();
      case ($urandom_range(0, 9))
        0, 1: pending_items.push_back(make_row(2'($urandom_range(0, 1)), 2'($urandom),
                                               rand_q(), rand_q(), rand_q(), rand_q()));
        2: begin
          it = make_box($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
          it.kind = 2'($urandom_range(0, 3));
          pending_items.push_back(it);
        end
        3: begin
          if ($urandom_range(0, 1)) load_identity(csbc_pkg::KIND_LOAD_VP);
          else load_identity(csbc_pkg::KIND_LOAD_MODEL);
        end
        default: pending_items.push_back(make_box(rand_q(), rand_q(), rand_q(),
                                                  rand_q(), rand_q(), rand_q()));
      endcase
      queued += pending_items.size() - before_sz;
    end
    wait (pending_items.size() < 100);
    calm_phase = 1'b1;
    wait (pending_items.size() == 0);
    stimulus_done = 1'b1;
  end

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_item(in_data);
        void'(pending_items.pop_front());
      end
      if (in_valid && !in_ready) begin
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (!calm_phase && $urandom_range(0, 15) == 0) begin
        send_gap <= $urandom_range(1, 19);
        in_valid <= 1'b0;
      end else if (pending_items.size() > (in_valid && in_ready ? 1 : 0)) begin
        in_valid <= 1'b1;
        in_data <= (in_valid && in_ready) ? pending_items[1] : pending_items[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    csbc_pkg::out_item_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_verdicts.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat, expected none, actual %p", $time, out_data);
        end else begin
          want = expected_verdicts.pop_front();
          if (out_data.visible !== want.visible) begin
            errors++;
            $display("%0t: visible expected %0d actual %0d", $time, want.visible,
                     out_data.visible);
          end
          if (out_data.separating_axes !== want.separating_axes) begin
            errors++;
            $display("%0t: separating_axes expected %0d actual %0d", $time,
                     want.separating_axes, out_data.separating_axes);
          end
        end
      end
      if (hold_req && !hold_started) begin
        hold_started <= 1'b1;
        hold_off_cycles <= 300;
        out_ready <= 1'b0;
      end else if (hold_off_cycles > 0) begin
        hold_off_cycles <= hold_off_cycles - 1;
        out_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_ready <= 1'b0;
      end else if (!calm_phase && $urandom_range(0, 15) == 0) begin
        recv_gap <= $urandom_range(1, 19);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == 3) rst_n <= 1'b1;
    if (cycle_count > 400000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    wait (stimulus_done);
    wait (expected_verdicts.size() == 0);
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/csbc_pkg.sv
sv/csbc_datapath.sv
sv/csbc_ctrl.sv
sv/clip_space_box_cull_unit.sv
bench/clip_space_box_cull_unit_tb.sv
